// ----- hw/rtl/ppge_pkg.sv -----
// Shared types, codes and helpers of the packed pixel palette/gamma expander.
`timescale 1ns / 1ps
`default_nettype none
package ppge_pkg;

  localparam int TBL_AW  = 8;
  localparam int COLOR_W = 24;
  localparam int GEOM_W  = 12;
  localparam int WORD_W  = 32;
  localparam int KIDX_W  = 5;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_PIXEL  = 2'd0,
    OP_PAL_WR = 2'd1,
    OP_GAM_WR = 2'd2
  } op_t;

  // Bits-per-pixel codes held in the depth register.
  typedef enum logic [2:0] {
    DEPTH_1  = 3'd0,
    DEPTH_2  = 3'd1,
    DEPTH_4  = 3'd2,
    DEPTH_8  = 3'd3,
    DEPTH_16 = 3'd4,
    DEPTH_24 = 3'd5
  } depth_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_DEPTH  = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  // Work kinds held in the queue between front and back.
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_PAL_WR = 2'd1,
    KIND_GAM_WR = 2'd2
  } kind_t;

  // For table writes, data holds {entry_index, entry_color}.
  typedef struct packed {
    kind_t               kind;
    logic [WORD_W-1:0]   data;
  } q_entry_t;

  typedef struct packed {
    logic                pal_en;
    logic                gam_en;
    logic [TBL_AW-1:0]   idx;
    logic [COLOR_W-1:0]  color;
  } tbl_wr_t;

  typedef struct packed {
    logic [TBL_AW-1:0]   idx;
    logic                direct;
    logic [COLOR_W-1:0]  rgb;
    logic                word_done;
    logic                line_end;
    logic                frame_end;
  } pix_t;

  // Widen a 5-bit channel to 8 bits by repeating its top bits.
  function automatic logic [7:0] widen5(input logic [4:0] c);
    widen5 = {c, c[4:2]};
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ppge_fifo.sv -----
// Short queue between the classifying front end and the pixel back end.
`timescale 1ns / 1ps
`default_nettype none
module ppge_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ppge_pkg::q_entry_t push_entry,
  input  wire logic              pop,
  output ppge_pkg::q_entry_t     head,
  output logic                   empty,
  output logic                   full
);
  import ppge_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic [PW-1:0]   wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ppge_front.sv -----
// Front end: accept input items, drop those that do nothing, queue the rest.
`timescale 1ns / 1ps
`default_nettype none
module ppge_front (
  input  wire logic                          in_valid,
  input  wire logic [1:0]                    in_operation,
  input  wire logic [ppge_pkg::WORD_W-1:0]   in_pixel_word,
  input  wire logic [ppge_pkg::TBL_AW-1:0]   in_entry_index,
  input  wire logic [ppge_pkg::COLOR_W-1:0]  in_entry_color,
  input  wire logic                          width_zero,
  input  wire logic                          q_full,
  output logic                               in_stall,
  output logic                               push,
  output ppge_pkg::q_entry_t                 push_entry
);
  import ppge_pkg::*;

  logic keep;

  assign in_stall = q_full;

  always_comb begin
    keep            = 1'b0;
    push_entry.kind = KIND_PIXEL;
    push_entry.data = in_pixel_word;
    case (op_t'(in_operation))
      OP_PIXEL: begin
        // a zero-width line produces nothing and moves no counter
        keep = !width_zero;
      end
      OP_PAL_WR: begin
        keep            = 1'b1;
        push_entry.kind = KIND_PAL_WR;
        push_entry.data = {in_entry_index, in_entry_color};
      end
      OP_GAM_WR: begin
        keep            = 1'b1;
        push_entry.kind = KIND_GAM_WR;
        push_entry.data = {in_entry_index, in_entry_color};
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = in_valid && !q_full && keep;

endmodule
`default_nettype wire

// ----- hw/rtl/ppge_seq.sv -----
// Back-end sequencer: walk the pixels of a word and track line/frame position.
`timescale 1ns / 1ps
`default_nettype none
module ppge_seq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ppge_pkg::depth_t             depth,
  input  wire logic [ppge_pkg::GEOM_W-1:0]  line_width,
  input  wire logic [ppge_pkg::GEOM_W-1:0]  frame_height,
  input  wire logic                         pos_clear,
  input  wire logic                         adv,
  input  wire ppge_pkg::q_entry_t           head,
  input  wire logic                         q_empty,
  output logic                              pop,
  output logic                              iss_valid,
  output ppge_pkg::pix_t                    iss_pix,
  output ppge_pkg::tbl_wr_t                 tbl_wr
);
  import ppge_pkg::*;

  logic [KIDX_W-1:0]  k_r;
  logic [GEOM_W-1:0]  col_r;
  logic [GEOM_W-1:0]  row_r;
  logic [KIDX_W-1:0]  k_nxt;
  logic [GEOM_W-1:0]  col_nxt;
  logic [GEOM_W-1:0]  row_nxt;

  logic               go;
  logic               is_pixel;
  logic [KIDX_W-1:0]  last_k;
  logic [KIDX_W-1:0]  shamt;
  logic [WORD_W-1:0]  shifted;
  logic [15:0]        half;
  logic               eol;
  logic               eof;
  logic               last_px;

  assign go       = adv && !q_empty;
  assign is_pixel = (head.kind == KIND_PIXEL);

  always_comb begin
    case (depth)
      DEPTH_1:  last_k = KIDX_W'(31);
      DEPTH_2:  last_k = KIDX_W'(15);
      DEPTH_4:  last_k = KIDX_W'(7);
      DEPTH_8:  last_k = KIDX_W'(3);
      DEPTH_16: last_k = KIDX_W'(1);
      default:  last_k = '0;
    endcase
  end

  // bring pixel k of an indexed word to the top of the word
  assign shamt   = KIDX_W'(k_r << depth[1:0]);
  assign shifted = head.data << shamt;
  assign half    = (k_r == '0) ? head.data[31:16] : head.data[15:0];

  assign eol = ({1'b0, col_r} + 13'd1) >= {1'b0, line_width};
  assign eof = eol && (frame_height != '0) &&
               (({1'b0, row_r} + 13'd1) >= {1'b0, frame_height});
  assign last_px = (k_r == last_k) || eol;

  always_comb begin
    iss_pix.idx       = '0;
    iss_pix.direct    = 1'b1;
    iss_pix.rgb       = head.data[23:0];
    iss_pix.word_done = last_px;
    iss_pix.line_end  = eol;
    iss_pix.frame_end = eof;
    case (depth)
      DEPTH_1: begin
        iss_pix.direct = 1'b0;
        iss_pix.idx    = {7'd0, shifted[31]};
      end
      DEPTH_2: begin
        iss_pix.direct = 1'b0;
        iss_pix.idx    = {6'd0, shifted[31:30]};
      end
      DEPTH_4: begin
        iss_pix.direct = 1'b0;
        iss_pix.idx    = {4'd0, shifted[31:28]};
      end
      DEPTH_8: begin
        iss_pix.direct = 1'b0;
        iss_pix.idx    = shifted[31:24];
      end
      DEPTH_16: begin
        iss_pix.rgb = {widen5(half[14:10]), widen5(half[9:5]), widen5(half[4:0])};
      end
      default: begin
        iss_pix.rgb = head.data[23:0];
      end
    endcase
  end

  assign iss_valid    = go && is_pixel;
  assign tbl_wr.pal_en = go && (head.kind == KIND_PAL_WR);
  assign tbl_wr.gam_en = go && (head.kind == KIND_GAM_WR);
  assign tbl_wr.idx    = head.data[31:24];
  assign tbl_wr.color  = head.data[23:0];
  assign pop           = go && (!is_pixel || last_px);

  always_comb begin
    k_nxt   = k_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (iss_valid) begin
      k_nxt = last_px ? '0 : k_r + 1'b1;
      if (eol) begin
        col_nxt = '0;
        row_nxt = eof ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || pos_clear) begin
      k_r   <= '0;
      col_r <= '0;
      row_r <= '0;
    end else begin
      k_r   <= k_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

`ifndef SYNTHESIS
  a_col_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    (line_width != '0) |-> (col_r < line_width))
    else $error("column position past line width");

  a_k_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= last_k)
    else $error("pixel slot past end of word");

  a_eol_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (iss_valid && iss_pix.line_end && !pos_clear) |=> (col_r == '0))
    else $error("column not restarted after line end");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/ppge_lut.sv -----
// Palette and gamma lookup pipeline with the output register.
`timescale 1ns / 1ps
`default_nettype none
module ppge_lut (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               iss_valid,
  input  wire ppge_pkg::pix_t     iss_pix,
  input  wire ppge_pkg::tbl_wr_t  tbl_wr,
  input  wire logic               out_stall,
  output logic                    adv,
  output logic                    out_valid,
  output logic [ppge_pkg::COLOR_W-1:0] out_pixel_color,
  output logic                    out_word_done,
  output logic                    out_line_end,
  output logic                    out_frame_end
);
  import ppge_pkg::*;

  localparam int ENTRIES = 1 << TBL_AW;

  logic [COLOR_W-1:0] pal_mem [ENTRIES];
  logic [7:0]         gr_mem  [ENTRIES];
  logic [7:0]         gg_mem  [ENTRIES];
  logic [7:0]         gb_mem  [ENTRIES];
  logic [ENTRIES-1:0] pal_vld_r;
  logic [ENTRIES-1:0] gam_vld_r;

  logic               v1_r;
  logic               v2_r;
  pix_t               s1_r;
  pix_t               s2_r;
  logic [COLOR_W-1:0] pal_q_r;
  logic               pal_qv_r;
  logic [7:0]         gr_q_r, gg_q_r, gb_q_r;
  logic               gr_qv_r, gg_qv_r, gb_qv_r;
  logic [7:0]         ra_r, ga_r, ba_r;

  logic [COLOR_W-1:0] pal_val;
  logic [COLOR_W-1:0] rgb1;

  // whole pipeline moves together; it holds while a result sits stalled
  assign adv = !v2_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= iss_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= iss_pix;
      s2_r <= s1_r;
    end
  end

  // palette: unwritten entries read as 255-i per channel
  always_ff @(posedge clk) begin
    if (tbl_wr.pal_en) begin
      pal_mem[tbl_wr.idx] <= tbl_wr.color;
    end
    if (adv) begin
      pal_q_r <= pal_mem[iss_pix.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_vld_r <= '0;
    end else if (tbl_wr.pal_en) begin
      pal_vld_r[tbl_wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pal_qv_r <= pal_vld_r[iss_pix.idx];
    end
  end

  assign pal_val = pal_qv_r ? pal_q_r : {3{~s1_r.idx}};
  assign rgb1    = s1_r.direct ? s1_r.rgb : pal_val;

  // gamma: one memory per channel; unwritten entries read as i
  always_ff @(posedge clk) begin
    if (tbl_wr.gam_en) begin
      gr_mem[tbl_wr.idx] <= tbl_wr.color[23:16];
      gg_mem[tbl_wr.idx] <= tbl_wr.color[15:8];
      gb_mem[tbl_wr.idx] <= tbl_wr.color[7:0];
    end
    if (adv) begin
      gr_q_r <= gr_mem[rgb1[23:16]];
      gg_q_r <= gg_mem[rgb1[15:8]];
      gb_q_r <= gb_mem[rgb1[7:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gam_vld_r <= '0;
    end else if (tbl_wr.gam_en) begin
      gam_vld_r[tbl_wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gr_qv_r <= gam_vld_r[rgb1[23:16]];
      gg_qv_r <= gam_vld_r[rgb1[15:8]];
      gb_qv_r <= gam_vld_r[rgb1[7:0]];
      ra_r    <= rgb1[23:16];
      ga_r    <= rgb1[15:8];
      ba_r    <= rgb1[7:0];
    end
  end

  assign out_valid       = v2_r;
  assign out_pixel_color = {gr_qv_r ? gr_q_r : ra_r,
                            gg_qv_r ? gg_q_r : ga_r,
                            gb_qv_r ? gb_q_r : ba_r};
  assign out_word_done   = s2_r.word_done;
  assign out_line_end    = s2_r.line_end;
  assign out_frame_end   = s2_r.frame_end;

endmodule
`default_nettype wire

// ----- hw/rtl/packed_pixel_palette_gamma_expand_top.sv -----
// Top level of the packed pixel palette/gamma expander.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer: a 32-bit
//   video memory word (first byte in bits 31:24), a palette entry write or a
//   gamma entry write. Output channel (out_valid / out_stall) carries one pixel
//   per transfer as RRGGBB with word_done, line_end and frame_end flags.
//   Configuration (cfg_valid / cfg_ready, always ready) sets depth, line width
//   and frame height; any write to these registers restarts the line and frame position. Write it
//   only while the block is idle.
// Throughput: the back end emits one pixel per cycle while out_stall does not
//   hold it; a word holds 32 pixels at 1 bpp down to 1 at 24 bpp (4 at 8 bpp)
//   and the pixel walker is the limit. Ignored items never reach the queue.
//   The front queue keeps taking items while the back end works.
// Pipeline: a word passes the queue write, the palette read and the gamma read
//   registers before its first pixel shows on the output.
// Stall: out_stall freezes the whole lookup pipeline; the queue fills and then
//   raises in_stall. Nothing is dropped.
// Reset: synchronous, active low; tables return to their default contents at
//   once through per-entry valid bits, no clearing pass.
module packed_pixel_palette_gamma_expand_top #(
  parameter int MAX_LINE_WIDTH   = 3840,
  parameter int MAX_FRAME_HEIGHT = 2160,
  parameter int QUEUE_DEPTH      = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_operation,
  input  wire logic [ppge_pkg::WORD_W-1:0]   in_pixel_word,
  input  wire logic [ppge_pkg::TBL_AW-1:0]   in_entry_index,
  input  wire logic [ppge_pkg::COLOR_W-1:0]  in_entry_color,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ppge_pkg::COLOR_W-1:0]       out_pixel_color,
  output logic                               out_word_done,
  output logic                               out_line_end,
  output logic                               out_frame_end,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [ppge_pkg::GEOM_W-1:0]   cfg_data
);
  import ppge_pkg::*;

  localparam logic [GEOM_W-1:0] WIDTH_LIMIT  = GEOM_W'(MAX_LINE_WIDTH);
  localparam logic [GEOM_W-1:0] HEIGHT_LIMIT = GEOM_W'(MAX_FRAME_HEIGHT);

  depth_t             depth_r;
  logic [GEOM_W-1:0]  width_r;
  logic [GEOM_W-1:0]  height_r;
  depth_t             depth_nxt;
  logic [GEOM_W-1:0]  width_nxt;
  logic [GEOM_W-1:0]  height_nxt;
  logic               pos_clear;
  logic               cfg_xfer;

  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  logic               q_full;
  q_entry_t           q_in;
  q_entry_t           q_head;
  logic               adv;
  logic               iss_valid;
  pix_t               iss_pix;
  tbl_wr_t            tbl_wr;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  // register writes: undefined depths fall back to 1 bpp, geometry saturates
  always_comb begin
    depth_nxt  = depth_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    pos_clear  = 1'b0;
    if (cfg_xfer) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEPTH: begin
          depth_nxt = (cfg_data[2:0] > DEPTH_24) ? DEPTH_1 : depth_t'(cfg_data[2:0]);
          pos_clear = 1'b1;
        end
        REG_WIDTH: begin
          width_nxt = (cfg_data > WIDTH_LIMIT) ? WIDTH_LIMIT : cfg_data;
          pos_clear = 1'b1;
        end
        REG_HEIGHT: begin
          height_nxt = (cfg_data > HEIGHT_LIMIT) ? HEIGHT_LIMIT : cfg_data;
          pos_clear  = 1'b1;
        end
        default: begin
          pos_clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= DEPTH_1;
      width_r  <= GEOM_W'(640);
      height_r <= GEOM_W'(480);
    end else begin
      depth_r  <= depth_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  ppge_front u_front (
    .in_valid       (in_valid),
    .in_operation   (in_operation),
    .in_pixel_word  (in_pixel_word),
    .in_entry_index (in_entry_index),
    .in_entry_color (in_entry_color),
    .width_zero     (width_r == '0),
    .q_full         (q_full),
    .in_stall       (in_stall),
    .push           (q_push),
    .push_entry     (q_in)
  );

  ppge_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  ppge_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .depth        (depth_r),
    .line_width   (width_r),
    .frame_height (height_r),
    .pos_clear    (pos_clear),
    .adv          (adv),
    .head         (q_head),
    .q_empty      (q_empty),
    .pop          (q_pop),
    .iss_valid    (iss_valid),
    .iss_pix      (iss_pix),
    .tbl_wr       (tbl_wr)
  );

  ppge_lut u_lut (
    .clk             (clk),
    .rst_n           (rst_n),
    .iss_valid       (iss_valid),
    .iss_pix         (iss_pix),
    .tbl_wr          (tbl_wr),
    .out_stall       (out_stall),
    .adv             (adv),
    .out_valid       (out_valid),
    .out_pixel_color (out_pixel_color),
    .out_word_done   (out_word_done),
    .out_line_end    (out_line_end),
    .out_frame_end   (out_frame_end)
  );

endmodule
`default_nettype wire
